>>> sv/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg
// Shared types and constants for the servo status packet checker.
// ----------------------------------------------------------------------------
package sspc_pkg;

  // Largest number of data bytes that a status packet can carry.
  localparam int MAX_DATA_BYTES = 8;
  localparam int DATA_W         = 8 * MAX_DATA_BYTES;

  // Packet layout: byte positions within the status packet.
  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [3:0] POS_ID   = 4'd2;
  localparam logic [3:0] POS_ERR  = 4'd4;
  localparam logic [3:0] POS_DATA = 4'd5;

  // Millisecond counter saturates at its all-ones value.
  localparam logic [9:0] ELAPSED_MAX = 10'h3FF;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_EXPECTED_ID = 2'd0;
  localparam logic [1:0] CFG_DATA_LEN    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd2;

  localparam logic [7:0] EXPECTED_ID_RST = 8'd1;
  localparam logic [3:0] DATA_LEN_RST    = 4'd2;
  localparam logic [9:0] TIMEOUT_MS_RST  = 10'd10;

  // Kind of input word.
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  // Result codes.
  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_TIMEOUT = 2'd1,
    RES_FRAME   = 2'd2,
    RES_SERVO   = 2'd3
  } result_t;

  // One result word.
  typedef struct packed {
    result_t            code;
    logic [DATA_W-1:0]  read_data;
    logic [7:0]         err_bits;
  } sspc_result_t;

endpackage

>>> sv/servo_status_packet_checker.sv
// ----------------------------------------------------------------------------
// servo_status_packet_checker
// Checks a protocol-1 style servo status packet received one byte per word.
// ----------------------------------------------------------------------------
// A start word arms the checker; byte words then carry the packet (two 0xFF
// header bytes, ID, length, error byte, data bytes, checksum), and tick words
// count milliseconds toward the timeout. The packet state updates in the cycle
// the word is accepted and any result lands in the output register on the same
// edge, so a new word is accepted every cycle while the output register is
// empty or being drained. One result is produced per completed or timed-out
// packet; other words produce none.
// ----------------------------------------------------------------------------
module servo_status_packet_checker
  import sspc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  logic [1:0]          s_tuser,   // [1:0] mode
  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W+7:0]   m_tdata,   // [63:0] read_data, [71:64] servo_error_bits
  output logic [1:0]          m_tuser,   // [1:0] result_code
  // Configuration writes.
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data
);

  logic         [7:0] expected_id;
  logic         [3:0] data_len;
  logic         [9:0] timeout_ms;
  logic               step;
  logic               res_fire;
  sspc_result_t       res;
  sspc_result_t       out_reg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= EXPECTED_ID_RST;
      data_len    <= DATA_LEN_RST;
      timeout_ms  <= TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID: expected_id <= cfg_data[7:0];
        CFG_DATA_LEN:    data_len    <= cfg_data[3:0];
        CFG_TIMEOUT_MS:  timeout_ms  <= cfg_data;
        default: begin
          // Index past the register list: write is dropped.
        end
      endcase
    end
  end

  // A word is taken whenever the output register is free or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  sspc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .mode        (mode_t'(s_tuser)),
    .rx_byte     (s_tdata),
    .expected_id (expected_id),
    .data_len    (data_len),
    .timeout_ms  (timeout_ms),
    .res_fire    (res_fire),
    .res         (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= step && res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_fire) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {out_reg.err_bits, out_reg.read_data};
  assign m_tuser = out_reg.code;

endmodule

>>> sv/sspc_parser.sv
// ----------------------------------------------------------------------------
// sspc_parser
// Packet state and per-word decode: header, ID, checksum and timeout checks.
// ----------------------------------------------------------------------------
module sspc_parser
  import sspc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mode_t              mode,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         expected_id,
  input  logic [3:0]         data_len,
  input  logic [9:0]         timeout_ms,
  output logic               res_fire,
  output sspc_result_t       res
);

  logic              busy;
  logic [3:0]        byte_count;
  logic [7:0]        running_sum;
  logic              frame_bad;
  logic [7:0]        error_byte;
  logic [DATA_W-1:0] data_shift;
  logic [9:0]        elapsed_ms;

  logic              busy_next;
  logic [3:0]        byte_count_next;
  logic [7:0]        running_sum_next;
  logic              frame_bad_next;
  logic [7:0]        error_byte_next;
  logic [DATA_W-1:0] data_shift_next;
  logic [9:0]        elapsed_ms_next;

  logic [3:0]        eff_len;
  logic [3:0]        chk_pos;
  logic [2:0]        lane;
  logic [9:0]        elapsed_inc;
  logic              sum_bad;

  // Data length saturates at the widest packet, and the checksum follows it.
  assign eff_len     = (data_len > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : data_len;
  assign chk_pos     = POS_DATA + eff_len;
  assign lane        = 3'(byte_count - POS_DATA);
  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 10'd1;
  assign sum_bad     = (~running_sum) != rx_byte;

  // Next packet state and the result that this word causes.
  always_comb begin
    busy_next        = busy;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    frame_bad_next   = frame_bad;
    error_byte_next  = error_byte;
    data_shift_next  = data_shift;
    elapsed_ms_next  = elapsed_ms;
    res_fire         = 1'b0;
    res.code         = RES_OK;
    res.read_data    = '0;
    res.err_bits     = '0;

    unique case (mode)
      MODE_START: begin
        busy_next        = 1'b1;
        byte_count_next  = '0;
        running_sum_next = '0;
        frame_bad_next   = 1'b0;
        error_byte_next  = '0;
        data_shift_next  = '0;
        elapsed_ms_next  = '0;
      end
      MODE_BYTE: begin
        if (busy) begin
          if (byte_count >= chk_pos) begin
            // Checksum byte closes the packet; frame errors win over servo errors.
            res_fire     = 1'b1;
            res.err_bits = error_byte;
            if (frame_bad || sum_bad) begin
              res.code = RES_FRAME;
            end else if (error_byte != 8'd0) begin
              res.code = RES_SERVO;
            end else begin
              res.code      = RES_OK;
              res.read_data = data_shift;
            end
            busy_next        = 1'b0;
            byte_count_next  = '0;
            running_sum_next = '0;
            frame_bad_next   = 1'b0;
            error_byte_next  = '0;
            data_shift_next  = '0;
            elapsed_ms_next  = '0;
          end else begin
            if (byte_count < POS_ID) begin
              if (rx_byte != HDR_BYTE) frame_bad_next = 1'b1;
            end else begin
              if (byte_count == POS_ID && rx_byte != expected_id) frame_bad_next = 1'b1;
              if (byte_count == POS_ERR) error_byte_next = rx_byte;
              if (byte_count >= POS_DATA) begin
                data_shift_next[{lane, 3'b000} +: 8] = data_shift[{lane, 3'b000} +: 8] | rx_byte;
              end
              running_sum_next = running_sum + rx_byte;
            end
            byte_count_next = byte_count + 4'd1;
          end
        end
      end
      MODE_TICK: begin
        if (busy) begin
          if (elapsed_inc >= timeout_ms) begin
            // Timeout aborts the packet.
            res_fire         = 1'b1;
            res.code         = RES_TIMEOUT;
            busy_next        = 1'b0;
            byte_count_next  = '0;
            running_sum_next = '0;
            frame_bad_next   = 1'b0;
            error_byte_next  = '0;
            data_shift_next  = '0;
            elapsed_ms_next  = '0;
          end else begin
            elapsed_ms_next = elapsed_inc;
          end
        end
      end
      default: begin
        // Unused mode code: no effect.
      end
    endcase
  end

  // Packet state registers advance once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
      frame_bad   <= 1'b0;
      error_byte  <= '0;
      data_shift  <= '0;
      elapsed_ms  <= '0;
    end else if (step) begin
      busy        <= busy_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      frame_bad   <= frame_bad_next;
      error_byte  <= error_byte_next;
      data_shift  <= data_shift_next;
      elapsed_ms  <= elapsed_ms_next;
    end
  end

endmodule
